// ----- hw/rtl/npr_pkg.sv -----
// Shared types and constants of the nested region profiler.
`timescale 1ns / 1ps

package npr_pkg;

  localparam int STAMP_W    = 48;
  localparam int SUM_W      = 64;
  localparam int QTY_W      = 32;
  localparam int REG_W      = 4;
  localparam int LVL_W      = 5;
  localparam int ERR_W      = 2;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 368;

  localparam logic MODE_START = 1'b0;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic [QTY_W-1:0]   stops;
    logic [SUM_W-1:0]   qty_total;
    logic [QTY_W-1:0]   recent_qty;
    logic [SUM_W-1:0]   self_total;
    logic [STAMP_W-1:0] self_mark;
    logic [SUM_W-1:0]   incl_total;
    logic [STAMP_W-1:0] start_mark;
  } npr_acc_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_STK_RD,
    ST_STK_LAT,
    ST_ENT_RD,
    ST_ENT_LD,
    ST_INC_SUB,
    ST_INC_ADD,
    ST_QTY_ADD,
    ST_SELF_SUB,
    ST_SELF_ADD,
    ST_ENT_WR,
    ST_RPT_RD,
    ST_RPT_LD
  } npr_state_t;

  typedef enum logic [1:0] {
    PH_START_PARENT,
    PH_START_REGION,
    PH_STOP_REGION,
    PH_STOP_PARENT
  } npr_phase_t;

endpackage

// ----- hw/rtl/npr_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module npr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/nested_region_profiler_unit.sv -----
// Nested region profiler: per-region inclusive/self time table and open-region stack.
`timescale 1ns / 1ps

// Each input item starts or stops one region at a timestamp and returns one result item:
// the region's table entry after the event, the stack level and an error code. One item
// is worked on at a time; in_tready is high only while the sequencer is idle. A full or
// empty stack or an out-of-range region goes straight to the result; the next item can be
// taken in the cycle the result appears.
// Every read-modify-write of a table entry goes through the single-port table RAM, and
// every 48-bit difference and 64-bit sum goes, one per cycle, through one shared 64-bit
// adder. A stop that closes the outermost nesting and has a parent on the stack is the
// longest case. A finished result waits in an output register, so the next item may be
// accepted before it is taken. Table entries read as zero until first written (one valid
// flop per region); no clearing pass is needed after reset.
module nested_region_profiler_unit #(
  parameter int REGIONS     = 16,
  parameter int STACK_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // region[3:0], now_stamp[51:4], quantity[83:52], zero fill
  input  logic [npr_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // region_out[3:0], last_inclusive[51:4], inclusive_sum[115:52], last_exclusive[163:116],
  // exclusive_sum[227:164], last_quantity[259:228], quantity_sum[323:260],
  // stop_total[355:324], open_nesting[360:356], stack_level[365:361], zero fill
  output logic [npr_pkg::OUT_DATA_W-1:0] out_tdata,
  // error_code
  output logic [npr_pkg::ERR_W-1:0]      out_tuser
);

  import npr_pkg::*;

  localparam int RW     = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int SW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW     = $clog2(STACK_DEPTH + 1);
  localparam int ACC_W  = $bits(npr_acc_t);
  localparam int EW     = ACC_W + PW;
  localparam int PAD_W  = OUT_DATA_W - (REG_W + 3 * SUM_W + 2 * STAMP_W + 2 * QTY_W + 2 * LVL_W);

  npr_state_t state_r, state_nxt;
  npr_phase_t phase_r, phase_nxt;

  logic                  mode_r, mode_nxt;
  logic [REG_W-1:0]      region_r, region_nxt;
  logic [STAMP_W-1:0]    now_r, now_nxt;
  logic [QTY_W-1:0]      qty_r, qty_nxt;
  logic [ERR_W-1:0]      err_r, err_nxt;
  logic                  zero_r, zero_nxt;
  logic [RW-1:0]         target_r, target_nxt;
  logic [PW-1:0]         sp_r, sp_nxt;
  npr_acc_t              acc_r, acc_nxt;
  logic [PW-1:0]         open_r, open_nxt;
  logic [REGIONS-1:0]    valid_r, valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [ERR_W-1:0]      out_user_r;

  logic                  tbl_we;
  logic [EW-1:0]         tbl_rdata;
  logic                  stk_we;
  logic [REG_W-1:0]      stk_rdata;
  logic [PW-1:0]         sp_m1;

  logic                  ent_valid;
  npr_acc_t              ent_acc;
  logic [PW-1:0]         ent_open;
  npr_acc_t              rpt_acc;
  logic [PW-1:0]         rpt_open;

  logic [SUM_W-1:0]      add_a, add_b, add_sum;
  logic                  add_sub;
  logic                  ld_out;
  logic                  region_ok;

  npr_ram #(.WIDTH(EW), .DEPTH(REGIONS)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (target_r),
    .wdata ({open_r, acc_r}),
    .raddr (target_r),
    .rdata (tbl_rdata)
  );

  assign sp_m1 = sp_r - PW'(1);

  npr_ram #(.WIDTH(REG_W), .DEPTH(STACK_DEPTH)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (sp_r[SW-1:0]),
    .wdata (region_r),
    .raddr (sp_m1[SW-1:0]),
    .rdata (stk_rdata)
  );

  assign ent_valid = valid_r[target_r];
  assign ent_acc   = ent_valid ? npr_acc_t'(tbl_rdata[ACC_W-1:0]) : '0;
  assign ent_open  = ent_valid ? tbl_rdata[EW-1:ACC_W] : '0;
  assign rpt_acc   = zero_r ? '0 : ent_acc;
  assign rpt_open  = zero_r ? '0 : ent_open;
  assign region_ok = 32'(region_r) < REGIONS;

  // shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_r)
      ST_INC_SUB: begin
        add_a   = SUM_W'(now_r);
        add_b   = SUM_W'(acc_r.start_mark);
        add_sub = 1'b1;
      end
      ST_INC_ADD: begin
        add_a = acc_r.incl_total;
        add_b = SUM_W'(acc_r.start_mark);
      end
      ST_QTY_ADD: begin
        add_a = acc_r.qty_total;
        add_b = SUM_W'(qty_r);
      end
      ST_SELF_SUB: begin
        add_a   = SUM_W'(now_r);
        add_b   = SUM_W'(acc_r.self_mark);
        add_sub = 1'b1;
      end
      ST_SELF_ADD: begin
        add_a = acc_r.self_total;
        add_b = SUM_W'(acc_r.self_mark);
      end
      default: begin
        add_a = '0;
      end
    endcase
    add_sum = add_a + (add_b ^ {SUM_W{add_sub}}) + SUM_W'(add_sub);
  end

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    mode_nxt   = mode_r;
    region_nxt = region_r;
    now_nxt    = now_r;
    qty_nxt    = qty_r;
    err_nxt    = err_r;
    zero_nxt   = zero_r;
    target_nxt = target_r;
    sp_nxt     = sp_r;
    acc_nxt    = acc_r;
    open_nxt   = open_r;
    valid_nxt  = valid_r;
    tbl_we     = 1'b0;
    stk_we     = 1'b0;
    ld_out     = 1'b0;
    in_tready  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          mode_nxt   = in_tuser;
          region_nxt = in_tdata[REG_W-1:0];
          now_nxt    = in_tdata[REG_W +: STAMP_W];
          qty_nxt    = in_tdata[REG_W + STAMP_W +: QTY_W];
          state_nxt  = ST_DISP;
        end
      end
      ST_DISP: begin
        target_nxt = RW'(region_r);
        err_nxt    = ERR_OK;
        zero_nxt   = 1'b0;
        if (!region_ok) begin
          zero_nxt  = 1'b1;
          state_nxt = ST_RPT_LD;
        end else if (mode_r == MODE_START) begin
          if (32'(sp_r) >= STACK_DEPTH) begin
            err_nxt   = ERR_FULL;
            state_nxt = ST_RPT_RD;
          end else if (sp_r != '0) begin
            phase_nxt = PH_START_PARENT;
            state_nxt = ST_STK_RD;
          end else begin
            phase_nxt = PH_START_REGION;
            state_nxt = ST_ENT_RD;
          end
        end else begin
          if (sp_r == '0) begin
            err_nxt   = ERR_EMPTY;
            state_nxt = ST_RPT_RD;
          end else begin
            phase_nxt = PH_STOP_REGION;
            state_nxt = ST_ENT_RD;
          end
        end
      end
      ST_STK_RD: begin
        state_nxt = ST_STK_LAT;
      end
      ST_STK_LAT: begin
        target_nxt = RW'(stk_rdata);
        state_nxt  = ST_ENT_RD;
      end
      ST_ENT_RD: begin
        state_nxt = ST_ENT_LD;
      end
      ST_ENT_LD: begin
        acc_nxt  = ent_acc;
        open_nxt = ent_open;
        case (phase_r)
          PH_START_PARENT: begin
            state_nxt = ST_SELF_SUB;
          end
          PH_START_REGION: begin
            if (ent_open == '0) begin
              acc_nxt.start_mark = now_r;
            end
            open_nxt          = ent_open + PW'(1);
            acc_nxt.self_mark = now_r;
            state_nxt         = ST_ENT_WR;
          end
          PH_STOP_REGION: begin
            if (ent_open != '0) begin
              open_nxt = ent_open - PW'(1);
            end
            acc_nxt.recent_qty = qty_r;
            if (ent_acc.stops != {QTY_W{1'b1}}) begin
              acc_nxt.stops = ent_acc.stops + QTY_W'(1);
            end
            state_nxt = (ent_open == PW'(1)) ? ST_INC_SUB : ST_QTY_ADD;
          end
          PH_STOP_PARENT: begin
            acc_nxt.self_mark = now_r;
            state_nxt         = ST_ENT_WR;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_INC_SUB: begin
        acc_nxt.start_mark = add_sum[STAMP_W-1:0];
        state_nxt          = ST_INC_ADD;
      end
      ST_INC_ADD: begin
        acc_nxt.incl_total = add_sum;
        state_nxt          = ST_QTY_ADD;
      end
      ST_QTY_ADD: begin
        acc_nxt.qty_total = add_sum;
        state_nxt         = ST_SELF_SUB;
      end
      ST_SELF_SUB: begin
        acc_nxt.self_mark = add_sum[STAMP_W-1:0];
        state_nxt         = ST_SELF_ADD;
      end
      ST_SELF_ADD: begin
        acc_nxt.self_total = add_sum;
        state_nxt          = ST_ENT_WR;
      end
      ST_ENT_WR: begin
        tbl_we              = 1'b1;
        valid_nxt[target_r] = 1'b1;
        case (phase_r)
          PH_START_PARENT: begin
            phase_nxt  = PH_START_REGION;
            target_nxt = RW'(region_r);
            state_nxt  = ST_ENT_RD;
          end
          PH_START_REGION: begin
            stk_we    = 1'b1;
            sp_nxt    = sp_r + PW'(1);
            state_nxt = ST_RPT_RD;
          end
          PH_STOP_REGION: begin
            sp_nxt = sp_m1;
            if (sp_m1 != '0) begin
              phase_nxt = PH_STOP_PARENT;
              state_nxt = ST_STK_RD;
            end else begin
              state_nxt = ST_RPT_RD;
            end
          end
          PH_STOP_PARENT: begin
            target_nxt = RW'(region_r);
            state_nxt  = ST_RPT_RD;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_RPT_RD: begin
        state_nxt = ST_RPT_LD;
      end
      ST_RPT_LD: begin
        if (!out_valid_r || out_tready) begin
          ld_out    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = ld_out | (out_valid_r & ~out_tready);
  assign out_data_nxt  = {{PAD_W{1'b0}}, LVL_W'(sp_r), LVL_W'(rpt_open), rpt_acc.stops,
                          rpt_acc.qty_total, rpt_acc.recent_qty, rpt_acc.self_total,
                          rpt_acc.self_mark, rpt_acc.incl_total, rpt_acc.start_mark,
                          region_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sp_r        <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r  <= phase_nxt;
    mode_r   <= mode_nxt;
    region_r <= region_nxt;
    now_r    <= now_nxt;
    qty_r    <= qty_nxt;
    err_r    <= err_nxt;
    zero_r   <= zero_nxt;
    target_r <= target_nxt;
    acc_r    <= acc_nxt;
    open_r   <= open_nxt;
    if (ld_out) begin
      out_data_r <= out_data_nxt;
      out_user_r <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- hw/rtl/npr_checker.sv -----
// Port-level checks of the nested region profiler, bound to the top level.
`timescale 1ns / 1ps

module npr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [npr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [npr_pkg::ERR_W-1:0]      out_tuser
);

  import npr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ERR_EMPTY |-> out_tdata[365:361] == '0)
    else $error("empty-stack error with nonzero stack level");

endmodule

bind nested_region_profiler_unit npr_checker u_npr_checker (.*);
